// File: rtl/qimvd_pkg.sv
// Package for the QIM watermark vote decoder: word types, codes and constants.
package qimvd_pkg;

  localparam int REPEATS     = 11;
  localparam int TEXT_BYTES  = 15;
  localparam int SYNC_BYTES  = 16;
  localparam int TOTAL_BYTES = SYNC_BYTES + TEXT_BYTES + 1;
  localparam int BIT_W       = $clog2(TOTAL_BYTES * 8 + 1);
  localparam int BIDX_W      = BIT_W - 3;
  localparam int RPT_W       = 5;
  localparam int POS_W       = 5;

  localparam int STEP_W      = 12;
  localparam int MAG_W       = 16;
  localparam int NUM_W       = MAG_W + 1;
  localparam int DIV_W       = STEP_W + 1;
  localparam int REM_W       = DIV_W + 1;
  localparam int QUO_W       = 12;
  localparam int DCNT_W      = $clog2(QUO_W);

  localparam logic [STEP_W-1:0] MIN_STEP   = 12'd16;
  localparam logic [STEP_W-1:0] STEP_RESET = 12'd256;

  localparam logic [7:0] SYNC_WORDS [0:SYNC_BYTES-1] = '{
    8'hA3, 8'h5F, 8'hC1, 8'h7D, 8'h2B, 8'h9E, 8'h11, 8'hF0,
    8'h4C, 8'hD2, 8'h88, 8'hE7, 8'h33, 8'h19, 8'hBE, 8'h42
  };

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SYNC_FAIL = 2'd1,
    ST_SUM_FAIL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic               frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic [POS_W-1:0] byte_position;
    status_t          status;
    logic             last_result;
  } out_word_t;

endpackage

// File: rtl/qim_watermark_vote_decoder_top.sv
// QIM watermark vote decoder: serial QIM bit slicer, repeat vote, byte framing and emit.
// Each coefficient word passes S_IDLE, which accepts it and forms the numerator, S_DIV, a
// bit-serial restoring divide (one quotient bit per cycle, the quotient parity is the QIM
// bit), and S_VOTE, which updates the vote, byte and frame state. in_stall is high in S_DIV and S_VOTE.
// When the checksum byte completes, the block sends TEXT_BYTES payload words, or one
// failure word, at one word per cycle as out_stall allows, before it takes the next
// coefficient. quant_step is written through cfg_wr_en/cfg_wr_data; a value below 16 acts as 16.
module qim_watermark_vote_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [11:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qimvd_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qimvd_pkg::out_word_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_VOTE, S_EMIT} state_t;

  localparam int STEP_W = qimvd_pkg::STEP_W;
  localparam int NUM_W  = qimvd_pkg::NUM_W;
  localparam int DIV_W  = qimvd_pkg::DIV_W;
  localparam int REM_W  = qimvd_pkg::REM_W;
  localparam int QUO_W  = qimvd_pkg::QUO_W;
  localparam int DCNT_W = qimvd_pkg::DCNT_W;
  localparam int BIT_W  = qimvd_pkg::BIT_W;
  localparam int BIDX_W = qimvd_pkg::BIDX_W;
  localparam int RPT_W  = qimvd_pkg::RPT_W;
  localparam int POS_W  = qimvd_pkg::POS_W;
  localparam int TB     = qimvd_pkg::TEXT_BYTES;

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        quant_step_r;
  logic [DIV_W-1:0]         div_r, div_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         numsh_r, numsh_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic                     qbit_r, qbit_nxt;
  logic signed [5:0]        vote_sum_r, vote_sum_nxt;
  logic [RPT_W-1:0]         repeat_count_r, repeat_count_nxt;
  logic [BIT_W-1:0]         bit_count_r, bit_count_nxt;
  logic [7:0]               byte_shift_r, byte_shift_nxt;
  logic [7:0]               running_xor_r, running_xor_nxt;
  logic                     sync_good_r, sync_good_nxt;
  qimvd_pkg::status_t       emit_status_r, emit_status_nxt;
  logic [POS_W-1:0]         emit_cnt_r, emit_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  qimvd_pkg::out_word_t     out_data_r, out_data_nxt;
  logic [7:0]               pay_r [0:TB-1];
  logic                     pay_shift;
  logic [7:0]               pay_in;

  logic [STEP_W-1:0]        step_eff;
  logic [15:0]              mag;
  logic [NUM_W-1:0]         num;
  logic [REM_W-1:0]         trial;
  logic                     trial_ge;
  logic signed [5:0]        vs_new;
  logic [RPT_W-1:0]         rc_inc;
  logic                     vbit;
  logic [7:0]               bs_new;
  logic [BIT_W-1:0]         bc_inc;
  logic [BIDX_W-1:0]        bidx;
  logic                     out_free;

  assign step_eff = (quant_step_r < qimvd_pkg::MIN_STEP) ? qimvd_pkg::MIN_STEP : quant_step_r;
  assign mag      = in_data.coefficient[15] ? 16'(~in_data.coefficient + 16'sd1)
                                            : 16'(in_data.coefficient);
  assign num      = {mag, 1'b0} + NUM_W'(step_eff);
  assign trial    = {rem_r[REM_W-2:0], numsh_r[QUO_W-1]};
  assign trial_ge = trial >= REM_W'(div_r);
  assign vs_new   = vote_sum_r + (qbit_r ? 6'sd1 : -6'sd1);
  assign rc_inc   = repeat_count_r + RPT_W'(1);
  assign vbit     = !vs_new[5] && (vs_new != 6'sd0);
  assign bs_new   = {byte_shift_r[6:0], vbit};
  assign bc_inc   = bit_count_r + BIT_W'(1);
  assign bidx     = bc_inc[BIT_W-1:3] - BIDX_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt        = state_r;
    div_nxt          = div_r;
    rem_nxt          = rem_r;
    numsh_nxt        = numsh_r;
    dcnt_nxt         = dcnt_r;
    qbit_nxt         = qbit_r;
    vote_sum_nxt     = vote_sum_r;
    repeat_count_nxt = repeat_count_r;
    bit_count_nxt    = bit_count_r;
    byte_shift_nxt   = byte_shift_r;
    running_xor_nxt  = running_xor_r;
    sync_good_nxt    = sync_good_r;
    emit_status_nxt  = emit_status_r;
    emit_cnt_nxt     = emit_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    pay_shift        = 1'b0;
    pay_in           = bs_new;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          div_nxt   = {step_eff, 1'b0};
          rem_nxt   = REM_W'(num[NUM_W-1:QUO_W]);
          numsh_nxt = num[QUO_W-1:0];
          dcnt_nxt  = '0;
          if (in_data.frame_start) begin
            vote_sum_nxt     = '0;
            repeat_count_nxt = '0;
            bit_count_nxt    = '0;
            byte_shift_nxt   = '0;
            running_xor_nxt  = '0;
            sync_good_nxt    = 1'b1;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt   = trial_ge ? (trial - REM_W'(div_r)) : trial;
        qbit_nxt  = trial_ge;
        numsh_nxt = {numsh_r[QUO_W-2:0], 1'b0};
        dcnt_nxt  = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(QUO_W - 1)) begin
          state_nxt = S_VOTE;
        end
      end
      S_VOTE: begin
        state_nxt = S_IDLE;
        if (rc_inc < RPT_W'(qimvd_pkg::REPEATS)) begin
          vote_sum_nxt     = vs_new;
          repeat_count_nxt = rc_inc;
        end else begin
          vote_sum_nxt     = '0;
          repeat_count_nxt = '0;
          bit_count_nxt    = bc_inc;
          if (bc_inc[2:0] != 3'd0) begin
            byte_shift_nxt = bs_new;
          end else begin
            byte_shift_nxt = '0;
            if (bidx < BIDX_W'(qimvd_pkg::SYNC_BYTES)) begin
              if (bs_new != qimvd_pkg::SYNC_WORDS[bidx[3:0]]) begin
                sync_good_nxt = 1'b0;
              end
              running_xor_nxt = running_xor_r ^ bs_new;
            end else if (bidx < BIDX_W'(qimvd_pkg::SYNC_BYTES + TB)) begin
              pay_shift       = 1'b1;
              running_xor_nxt = running_xor_r ^ bs_new;
            end else begin
              // checksum byte: pick the outcome, clear the frame, then emit
              if (!sync_good_r) begin
                emit_status_nxt = qimvd_pkg::ST_SYNC_FAIL;
              end else if (running_xor_r != bs_new) begin
                emit_status_nxt = qimvd_pkg::ST_SUM_FAIL;
              end else begin
                emit_status_nxt = qimvd_pkg::ST_OK;
              end
              emit_cnt_nxt    = '0;
              bit_count_nxt   = '0;
              running_xor_nxt = '0;
              sync_good_nxt   = 1'b1;
              state_nxt       = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (emit_status_r == qimvd_pkg::ST_OK) begin
            out_data_nxt.text_byte     = pay_r[0];
            out_data_nxt.byte_position = emit_cnt_r;
            out_data_nxt.status        = qimvd_pkg::ST_OK;
            out_data_nxt.last_result   = (emit_cnt_r == POS_W'(TB - 1));
            pay_shift                  = 1'b1;
            pay_in                     = '0;
            emit_cnt_nxt               = emit_cnt_r + POS_W'(1);
            if (emit_cnt_r == POS_W'(TB - 1)) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_data_nxt.text_byte     = '0;
            out_data_nxt.byte_position = '0;
            out_data_nxt.status        = emit_status_r;
            out_data_nxt.last_result   = 1'b1;
            state_nxt                  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      quant_step_r   <= qimvd_pkg::STEP_RESET;
      vote_sum_r     <= '0;
      repeat_count_r <= '0;
      bit_count_r    <= '0;
      byte_shift_r   <= '0;
      running_xor_r  <= '0;
      sync_good_r    <= 1'b1;
      emit_status_r  <= qimvd_pkg::ST_OK;
      emit_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
      dcnt_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) begin
        quant_step_r <= cfg_wr_data;
      end
      vote_sum_r     <= vote_sum_nxt;
      repeat_count_r <= repeat_count_nxt;
      bit_count_r    <= bit_count_nxt;
      byte_shift_r   <= byte_shift_nxt;
      running_xor_r  <= running_xor_nxt;
      sync_good_r    <= sync_good_nxt;
      emit_status_r  <= emit_status_nxt;
      emit_cnt_r     <= emit_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      dcnt_r         <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    numsh_r    <= numsh_nxt;
    qbit_r     <= qbit_nxt;
    out_data_r <= out_data_nxt;
  end

  // payload bytes shift in at the tail while framing and out of the head while sending
  always_ff @(posedge clk) begin
    if (pay_shift) begin
      for (int i = 0; i < TB - 1; i++) begin
        pay_r[i] <= pay_r[i+1];
      end
      pay_r[TB-1] <= pay_in;
    end
  end

endmodule

// File: tb/qim_watermark_vote_decoder_top_tb.sv
// Self-checking testbench for the QIM watermark vote decoder top level.
module qim_watermark_vote_decoder_top_tb;

  typedef enum int {FR_GOOD, FR_SYNC_BAD, FR_SUM_BAD} frame_kind_t;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int N_DIRECTED = 24;

  // coefficient, frame_start; quant_step is at its reset value here
  localparam logic [16:0] DIRECTED [N_DIRECTED] = '{
    {16'sh0000, 1'b1}, {16'sh0001, 1'b0}, {16'shFFFF, 1'b0}, {16'sh7FFF, 1'b0},
    {16'sh8000, 1'b0}, {16'sh007F, 1'b0}, {16'sh0080, 1'b0}, {16'shFF80, 1'b0},
    {16'shFF81, 1'b0}, {16'sh017F, 1'b0}, {16'sh0180, 1'b0}, {16'shFE80, 1'b0},
    {16'sh7F80, 1'b1}, {16'sh8080, 1'b0}, {16'sh4000, 1'b0}, {16'shC000, 1'b0},
    {16'sh00FF, 1'b0}, {16'sh0100, 1'b0}, {16'sh7F7F, 1'b0}, {16'sh8001, 1'b0},
    {16'sh0000, 1'b1}, {16'sh7FFF, 1'b1}, {16'sh8000, 1'b0}, {16'sh0040, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [11:0]          cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  qimvd_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  qimvd_pkg::out_word_t out_data;

  qim_watermark_vote_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // decoder copy
  logic [11:0]          step_reg;
  int                   tally;
  int                   votes_seen;
  int                   bits_seen;
  logic [7:0]           shift_byte;
  logic [7:0]           xor_acc;
  logic                 sync_ok;
  logic [7:0]           text_mem [qimvd_pkg::TEXT_BYTES];
  qimvd_pkg::out_word_t text_due [$];

  qimvd_pkg::out_word_t due_word;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          held = 1'b0;
  int          hold_left = 0;

  task automatic clear_frame();
    tally = 0;
    votes_seen = 0;
    bits_seen = 0;
    shift_byte = '0;
    xor_acc = '0;
    sync_ok = 1'b1;
  endtask

  function automatic logic qim_bit(logic signed [15:0] c);
    int unsigned mag;
    int unsigned s;
    mag = c[15] ? 32'h10000 - int'(c[15:0]) : int'(c[15:0]);
    s = (step_reg < qimvd_pkg::MIN_STEP) ? int'(qimvd_pkg::MIN_STEP) : int'(step_reg);
    return 1'(((2 * mag + s) / (2 * s)) % 2);
  endfunction

  task automatic decode_coefficient(qimvd_pkg::in_word_t w);
    logic [7:0]           byte_val;
    int                   idx;
    qimvd_pkg::out_word_t r;
    if (w.frame_start) clear_frame();
    tally += qim_bit(w.coefficient) ? 1 : -1;
    votes_seen++;
    if (votes_seen < qimvd_pkg::REPEATS) return;
    shift_byte = {shift_byte[6:0], tally > 0};
    tally = 0;
    votes_seen = 0;
    bits_seen++;
    if (bits_seen % 8 != 0) return;
    byte_val = shift_byte;
    shift_byte = '0;
    idx = bits_seen / 8 - 1;
    if (idx < qimvd_pkg::SYNC_BYTES) begin
      if (byte_val != qimvd_pkg::SYNC_WORDS[idx]) sync_ok = 1'b0;
      xor_acc ^= byte_val;
      return;
    end
    if (idx < qimvd_pkg::SYNC_BYTES + qimvd_pkg::TEXT_BYTES) begin
      text_mem[idx - qimvd_pkg::SYNC_BYTES] = byte_val;
      xor_acc ^= byte_val;
      return;
    end
    r.text_byte = '0;
    r.byte_position = '0;
    r.last_result = 1'b1;
    if (!sync_ok) begin
      r.status = qimvd_pkg::ST_SYNC_FAIL;
      text_due = {text_due, r};
    end else if (xor_acc != byte_val) begin
      r.status = qimvd_pkg::ST_SUM_FAIL;
      text_due = {text_due, r};
    end else begin
      for (int i = 0; i < qimvd_pkg::TEXT_BYTES; i++) begin
        r.text_byte = text_mem[i];
        r.byte_position = qimvd_pkg::POS_W'(i);
        r.status = qimvd_pkg::ST_OK;
        r.last_result = (i == qimvd_pkg::TEXT_BYTES - 1);
        text_due = {text_due, r};
      end
    end
    clear_frame();
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (text_due.size() == 0) begin
          $error("result word with none expected");
          fail_count++;
        end else begin
          due_word = text_due.pop_front();
          if (out_data.text_byte !== due_word.text_byte) begin
            $error("text_byte: expected %0d, got %0d", due_word.text_byte, out_data.text_byte);
            fail_count++;
          end
          if (out_data.byte_position !== due_word.byte_position) begin
            $error("byte_position: expected %0d, got %0d",
                   due_word.byte_position, out_data.byte_position);
            fail_count++;
          end
          if (out_data.status !== due_word.status) begin
            $error("status: expected %0d, got %0d", due_word.status, out_data.status);
            fail_count++;
          end
          if (out_data.last_result !== due_word.last_result) begin
            $error("last_result: expected %0d, got %0d",
                   due_word.last_result, out_data.last_result);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) decode_coefficient(in_data);
    end
  end

  // receiver: random stall bursts, one long hold-off on the first result
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && !quiet) begin
        if (!held && out_valid) begin
          hold_left = LONG_HOLD;
          held = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 12);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(qimvd_pkg::in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_coef(logic want);
    logic signed [15:0] c;
    int unsigned        s;
    s = (step_reg < qimvd_pkg::MIN_STEP) ? int'(qimvd_pkg::MIN_STEP) : int'(step_reg);
    do begin
      if ($urandom_range(0, 1)) begin
        c = 16'($urandom);
      end else begin
        c = 16'($urandom_range(0, 4 * s));
        if ($urandom_range(0, 1)) c = -c;
      end
    end while (qim_bit(c) != want);
    return c;
  endfunction

  // one frame bit as a majority vote with random dissenters
  task automatic send_bit(logic b, logic fs);
    int                  agree_left;
    logic                want;
    qimvd_pkg::in_word_t w;
    agree_left = $urandom_range(qimvd_pkg::REPEATS / 2 + 1, qimvd_pkg::REPEATS);
    for (int left = qimvd_pkg::REPEATS; left > 0; left--) begin
      want = ($urandom_range(1, left) <= agree_left) ? b : !b;
      if (want == b) agree_left--;
      w.coefficient = pick_coef(want);
      w.frame_start = fs && (left == qimvd_pkg::REPEATS);
      send_word(w);
    end
  endtask

  task automatic send_frame(frame_kind_t kind, logic fs);
    logic [7:0] frame_bytes [qimvd_pkg::TOTAL_BYTES];
    logic [7:0] sum;
    int         bad;
    sum = '0;
    for (int i = 0; i < qimvd_pkg::TOTAL_BYTES - 1; i++)
      frame_bytes[i] = (i < qimvd_pkg::SYNC_BYTES) ? qimvd_pkg::SYNC_WORDS[i] : 8'($urandom);
    if (kind == FR_SYNC_BAD) begin
      bad = $urandom_range(0, qimvd_pkg::SYNC_BYTES - 1);
      frame_bytes[bad] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < qimvd_pkg::TOTAL_BYTES - 1; i++) sum ^= frame_bytes[i];
    frame_bytes[qimvd_pkg::TOTAL_BYTES - 1] = sum;
    if (kind == FR_SUM_BAD)
      frame_bytes[qimvd_pkg::TOTAL_BYTES - 1] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < qimvd_pkg::TOTAL_BYTES; i++)
      for (int k = 7; k >= 0; k--)
        send_bit(frame_bytes[i][k], fs && i == 0 && k == 7);
  endtask

  task automatic send_noise(int n);
    qimvd_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.coefficient = 16'($urandom);
      w.frame_start = ($urandom_range(0, 15) == 0);
      send_word(w);
    end
  endtask

  task automatic write_step(logic [11:0] v);
    in_valid <= 1'b0;
    while (text_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    step_reg = v;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    step_reg = qimvd_pkg::STEP_RESET;
    clear_frame();
    for (int i = 0; i < qimvd_pkg::TEXT_BYTES; i++) text_mem[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_word(qimvd_pkg::in_word_t'(DIRECTED[i]));

    write_step(12'd16);
    send_frame(FR_GOOD, 1'b1);
    send_frame(FR_SYNC_BAD, 1'($urandom_range(0, 1)));

    write_step(12'd4095);
    send_frame(FR_SUM_BAD, 1'b1);

    // no frame_start: the previous frame end cleared the counters
    write_step(12'd0);
    send_frame(FR_GOOD, 1'b0);

    write_step(12'd15);
    send_noise($urandom_range(1, 300));
    send_frame(FR_GOOD, 1'b1);

    quiet = 1'b1;
    write_step(12'($urandom_range(16, 4095)));
    send_frame(FR_GOOD, 1'b1);
    send_frame(frame_kind_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    while (text_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
